@@ rtl/sed_pkg.sv @@
package sed_pkg;

	// Width of the dividend, divisor and quotient fields.
	localparam int DATA_W = 16;

	// Width of a significant bit count of a DATA_W bit value (0..DATA_W).
	localparam int K_W = $clog2(DATA_W + 1);

	// Default number of estimate steps.
	localparam int DATA_BITS_DEF = 16;

	// Quotient returned for a zero divisor.
	localparam logic [DATA_W-1:0] QUO_DBZ = '1;

	// Working values of one division as it moves down the pipeline.
	typedef struct packed {
		logic [DATA_W-1:0] rem;
		logic [DATA_W-1:0] quo;
		logic [DATA_W-1:0] den;
		logic [K_W-1:0]    k;
		logic              dbz;
	} item_t;

	// Number of significant bits of a value: one more than the index of its top set bit.
	function automatic logic [K_W-1:0] sig_bits(input logic [DATA_W-1:0] v);
		logic [K_W-1:0] n;
		n = '0;
		for (int i = 0; i < DATA_W; i++) begin
			if (v[i]) begin
				n = K_W'(i + 1);
			end
		end
		return n;
	endfunction

endpackage

@@ rtl/sed_step.sv @@
// One estimate step in two register stages: the estimate and its product with the
// divisor are registered first, then the remainder and quotient are updated.
module sed_step (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  sed_pkg::item_t  in_item,
	output logic            out_valid,
	input  logic            out_ready,
	output sed_pkg::item_t  out_item
);

	logic                         a_valid_s1;
	sed_pkg::item_t               a_item_s1;
	logic [sed_pkg::DATA_W-1:0]   a_est_s1;
	logic [sed_pkg::DATA_W-1:0]   a_prod_s1;
	logic                         b_valid_s2;
	sed_pkg::item_t               b_item_s2;

	logic                         a_ready;
	logic                         b_ready;
	logic [sed_pkg::DATA_W-1:0]   est;
	logic [2*sed_pkg::DATA_W-1:0] prod_full;
	sed_pkg::item_t               b_next;

	// A stage may load when it is empty or its contents move on.
	assign b_ready  = !b_valid_s2 || out_ready;
	assign a_ready  = !a_valid_s1 || b_ready;
	assign in_ready = a_ready;

	// The estimate is the remainder shifted down by the divisor's bit count. Its product
	// with the divisor never exceeds the remainder, so the low half holds it exactly.
	assign est       = in_item.rem >> in_item.k;
	assign prod_full = est * in_item.den;

	// First stage: estimate and product.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_valid_s1 <= 1'b0;
		end else if (a_ready) begin
			a_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (a_ready && in_valid) begin
			a_item_s1 <= in_item;
			a_est_s1  <= est;
			a_prod_s1 <= prod_full[sed_pkg::DATA_W-1:0];
		end
	end

	// Second stage: subtract the product and accumulate the estimate.
	always_comb begin
		b_next     = a_item_s1;
		b_next.rem = a_item_s1.rem - a_prod_s1;
		b_next.quo = a_item_s1.quo + a_est_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b_valid_s2 <= 1'b0;
		end else if (b_ready) begin
			b_valid_s2 <= a_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (b_ready && a_valid_s1) begin
			b_item_s2 <= b_next;
		end
	end

	assign out_valid = b_valid_s2;
	assign out_item  = b_item_s2;

endmodule

@@ rtl/shift_estimate_divider.sv @@
// Unsigned 16-bit divider: each input transaction carries a dividend and a divisor, and
// each output transaction returns floor(dividend / divisor), or all ones with the
// divide-by-zero flag set when the divisor is zero. The remainder is reduced by DATA_BITS
// shift estimates, each followed by a subtraction of estimate times divisor, and a final
// correction adds one if the remainder still reaches the divisor; with too few steps
// for a given input the quotient is what those steps yield. The block is a pipeline of
// 2*DATA_BITS+2 register stages (an input stage that finds the divisor's bit count, two
// stages per estimate step around its 16x16 multiplier, and the output register), so
// without back-pressure one transaction is taken and one returned every cycle. Every stage
// has its own valid bit, so empty stages fill while the output waits.
module shift_estimate_divider #(
	parameter int DATA_BITS = sed_pkg::DATA_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // dividend [15:0], divisor [31:16]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // quotient [15:0]
	output logic        m_axis_tuser    // divide_by_zero [0]
);

	localparam int W = sed_pkg::DATA_W;

	logic                   in_valid_s0;
	sed_pkg::item_t         in_item_s0;
	logic                   in_ready;
	sed_pkg::item_t         in_item;

	logic                   step_valid [DATA_BITS+1];
	logic                   step_ready [DATA_BITS+1];
	sed_pkg::item_t         step_item  [DATA_BITS+1];

	logic                   out_valid_q;
	logic [W-1:0]           quotient_q;
	logic                   dbz_q;
	logic                   out_load;
	sed_pkg::item_t         fin_item;
	logic [W-1:0]           fin_quo;

	// Input stage: latch the operands and find the divisor's significant bit count.
	assign in_ready      = !in_valid_s0 || step_ready[0];
	assign s_axis_tready = in_ready;

	always_comb begin
		in_item.rem = s_axis_tdata[W-1:0];
		in_item.quo = '0;
		in_item.den = s_axis_tdata[2*W-1:W];
		in_item.k   = sed_pkg::sig_bits(s_axis_tdata[2*W-1:W]);
		in_item.dbz = (s_axis_tdata[2*W-1:W] == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s0 <= 1'b0;
		end else if (in_ready) begin
			in_valid_s0 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && s_axis_tvalid) begin
			in_item_s0 <= in_item;
		end
	end

	assign step_valid[0] = in_valid_s0;
	assign step_item[0]  = in_item_s0;

	// Chain of estimate steps.
	for (genvar g = 0; g < DATA_BITS; g++) begin : g_step
		sed_step u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (step_valid[g]),
			.in_ready  (step_ready[g]),
			.in_item   (step_item[g]),
			.out_valid (step_valid[g+1]),
			.out_ready (step_ready[g+1]),
			.out_item  (step_item[g+1])
		);
	end

	// Final correction and the zero-divisor override feed the output register.
	assign fin_item = step_item[DATA_BITS];
	assign fin_quo  = fin_item.quo + W'(fin_item.rem >= fin_item.den);
	assign out_load = !out_valid_q || m_axis_tready;
	assign step_ready[DATA_BITS] = out_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= step_valid[DATA_BITS];
		end
	end

	always_ff @(posedge clk) begin
		if (out_load && step_valid[DATA_BITS]) begin
			quotient_q <= fin_item.dbz ? sed_pkg::QUO_DBZ : fin_quo;
			dbz_q      <= fin_item.dbz;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = quotient_q;
	assign m_axis_tuser  = dbz_q;

`ifndef SYNTH
	// A flagged result always carries the all-ones quotient.
	a_dbz_quo: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == sed_pkg::QUO_DBZ)
		else $error("divide-by-zero result without all-ones quotient");

	// An empty input stage never refuses a transaction.
	a_in_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!in_valid_s0 |-> s_axis_tready)
		else $error("input refused with empty input stage");

	// The latched bit count matches the divisor: its top bit is set and nothing above it.
	a_k_ok: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid_s0 && !in_item_s0.dbz |->
		(in_item_s0.k != '0) && ((in_item_s0.den >> (in_item_s0.k - 1'b1)) == W'(1)))
		else $error("divisor bit count wrong");

	// A result that is not taken stays in the output register.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !m_axis_tready |=> out_valid_q && $stable(quotient_q))
		else $error("stalled result lost");
`endif

endmodule

@@ tb/shift_estimate_divider_tb.sv @@
module shift_estimate_divider_tb;

	// Field width shared with the design.
	localparam int DATA_W      = sed_pkg::DATA_W;
	// Estimate steps used by the instance, and its pipeline depth without back-pressure.
	localparam int STEPS       = sed_pkg::DATA_BITS_DEF;
	localparam int PIPE_DEPTH  = 2 * STEPS + 2;
	// Cycles without any transaction before the run is declared hung.
	localparam int STALL_LIMIT = 1000;

	// One division as predicted, with its operands kept for the mismatch message.
	typedef struct packed {
		logic [DATA_W-1:0] dividend;
		logic [DATA_W-1:0] divisor;
		logic [DATA_W-1:0] quotient;
		logic              divide_by_zero;
	} division_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;   // dividend [15:0], divisor [31:16]
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;   // quotient [15:0]
	logic        m_axis_tuser;   // divide_by_zero [0]

	division_t   pending_quotients[$];
	int unsigned mismatch_count;
	int unsigned quiet_cycles;
	bit          send_idle_en;
	bit          recv_idle_en;

	shift_estimate_divider #(
		.DATA_BITS(STEPS)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	// Free-running clock.
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Expected quotient: DATA_BITS shift estimates of the remainder, then one correction.
	function automatic division_t predict_quotient(input logic [DATA_W-1:0] dividend,
			input logic [DATA_W-1:0] divisor);
		division_t   r;
		logic [31:0] rem;
		logic [31:0] quo;
		logic [31:0] est;
		int unsigned width;
		r.dividend = dividend;
		r.divisor  = divisor;
		if (divisor == '0) begin
			r.quotient       = sed_pkg::QUO_DBZ;
			r.divide_by_zero = 1'b1;
			return r;
		end
		width = 0;
		for (int b = 0; b < DATA_W; b++) begin
			if (divisor[b]) begin
				width = b + 1;
			end
		end
		rem = 32'(dividend);
		quo = '0;
		repeat (STEPS) begin
			est = rem >> width;
			quo += est;
			rem -= est * 32'(divisor);
		end
		if (rem >= 32'(divisor)) begin
			quo += 1;
		end
		r.quotient       = quo[DATA_W-1:0];
		r.divide_by_zero = 1'b0;
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	// Offer one division and hold it until the input transaction completes.
	task automatic send_division(input logic [DATA_W-1:0] dividend,
			input logic [DATA_W-1:0] divisor);
		int unsigned gap;
		gap = send_idle_en ? $urandom_range(10, 0) : 0;
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {divisor, dividend};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		pending_quotients.push_back(predict_quotient(dividend, divisor));
	endtask

	// Random value whose significant bit count is drawn uniformly from 0 to DATA_W.
	function automatic logic [DATA_W-1:0] random_of_width();
		int unsigned width;
		logic [DATA_W-1:0] v;
		width = $urandom_range(DATA_W, 0);
		if (width == 0) begin
			return '0;
		end
		v = DATA_W'($urandom) & DATA_W'((32'd1 << width) - 1);
		v[width-1] = 1'b1;
		return v;
	endfunction

	// Result side: random back-pressure, and each output transaction checked in order.
	always @(posedge clk) begin : result_monitor
		division_t   want;
		int unsigned stall_cycles;
		if (!arst_n) begin
			stall_cycles = 0;
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (pending_quotients.size() == 0) begin
					report_mismatch($sformatf("unexpected result quotient=%0d dbz=%0b",
						m_axis_tdata, m_axis_tuser));
				end else begin
					want = pending_quotients.pop_front();
					if (m_axis_tdata !== want.quotient) begin
						report_mismatch($sformatf("%0d / %0d: quotient %0d, expected %0d",
							want.dividend, want.divisor, m_axis_tdata, want.quotient));
					end
					if (m_axis_tuser !== want.divide_by_zero) begin
						report_mismatch($sformatf("%0d / %0d: divide_by_zero %0b, expected %0b",
							want.dividend, want.divisor, m_axis_tuser, want.divide_by_zero));
					end
				end
				stall_cycles = recv_idle_en ? $urandom_range(10, 0) : 0;
			end else if (stall_cycles != 0) begin
				stall_cycles--;
			end
			m_axis_tready <= (stall_cycles == 0);
		end
	end

	// Watchdog: the run is hung when no transaction moves for too long.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Extremes of both operands, exact quotients and off-by-one remainders.
	task automatic test_extremes();
		send_division(16'd0, 16'd1);
		send_division(16'd65535, 16'd1);
		send_division(16'd1, 16'd1);
		send_division(16'd65535, 16'd65535);
		send_division(16'd65534, 16'd65535);
		send_division(16'd0, 16'd65535);
		send_division(16'd1, 16'd65535);
		send_division(16'd65535, 16'd2);
		send_division(16'd32768, 16'd32768);
		send_division(16'd32767, 16'd32768);
		send_division(16'd65535, 16'd32767);
		send_division(16'd12345, 16'd12345);
		send_division(16'd100, 16'd7);
		send_division(16'd65535, 16'd255);
		send_division(16'd65535, 16'd256);
		send_division(16'd65535, 16'd3);
	endtask

	// A zero divisor returns all ones with the flag set, whatever the dividend.
	task automatic test_zero_divisor();
		send_division(16'd0, 16'd0);
		send_division(16'd65535, 16'd0);
		send_division(16'd12345, 16'd0);
	endtask

	task automatic test_random_uniform(input int unsigned count);
		repeat (count) begin
			send_division(DATA_W'($urandom), DATA_W'($urandom));
		end
	endtask

	// Operands of every bit count, so each divisor width meets every dividend width.
	task automatic test_random_widths(input int unsigned count);
		repeat (count) begin
			send_division(random_of_width(), random_of_width());
		end
	endtask

	// Dividends at and around a multiple of the divisor exercise the final correction.
	task automatic test_near_multiples(input int unsigned count);
		int unsigned den;
		int unsigned mult;
		int          num;
		repeat (count) begin
			den  = (random_of_width() == '0) ? 1 : 32'(random_of_width());
			if (den == 0) begin
				den = 1;
			end
			mult = $urandom_range(65535 / den, 0);
			case ($urandom_range(3, 0))
				0: num = int'(mult * den) - 1;
				1: num = int'(mult * den);
				2: num = int'(mult * den) + 1;
				default: num = int'(mult * den + $urandom_range(den - 1, 0));
			endcase
			if (num < 0) begin
				num = 0;
			end else if (num > 65535) begin
				num = 65535;
			end
			send_division(DATA_W'(num), DATA_W'(den));
		end
	endtask

	initial begin
		arst_n         = 1'b0;
		s_axis_tvalid  = 1'b0;
		s_axis_tdata   = '0;
		m_axis_tready  = 1'b0;
		mismatch_count = 0;
		quiet_cycles   = 0;
		send_idle_en   = 1'b1;
		recv_idle_en   = 1'b1;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_extremes();
		test_zero_divisor();
		test_random_uniform(650);
		test_random_widths(500);

		// A stretch with no idling on either side keeps the pipeline full.
		send_idle_en = 1'b0;
		recv_idle_en = 1'b0;
		test_random_uniform(300);

		// Sender at full rate against a stalling receiver.
		recv_idle_en = 1'b1;
		test_near_multiples(300);

		s_axis_tvalid <= 1'b0;
		while (pending_quotients.size() != 0) @(posedge clk);
		repeat (PIPE_DEPTH + 10) @(posedge clk);

		if (mismatch_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
